// ----- rtl/clpf_pkg.sv -----
// Package for the current-loop pressure low-pass filter.
// Holds the controller state type, the command and status structs and the fixed constants.
// No dependencies.
package clpf_pkg;

   // Fixed field widths.
   localparam int unsigned PSI_W = 11;
   localparam int unsigned DT_W  = 16;
   localparam int unsigned T_W   = 16;

   // Transducer band and psi scaling: floor((2*raw - 799) * 29 / 64).
   localparam int unsigned RAW_LOW     = 400;
   localparam int unsigned RAW_HIGH    = 2000;
   localparam int unsigned CLAMP_W     = 11;
   localparam int unsigned SCALE_OFF   = 799;
   localparam int unsigned SCALE_MUL   = 29;
   localparam int unsigned SCALE_SHIFT = 6;

   localparam logic [T_W-1:0] T_RESET = 16'd500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_in;
      logic mul_en;
      logic div_init;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
   } status_type;

endpackage

// ----- rtl/clpf_datapath.sv -----
// Datapath of the current-loop pressure low-pass filter: psi scaling, products,
// weighted sum, a restoring divider and the filter state.
// Depends on clpf_pkg.
module clpf_datapath #(
   parameter int unsigned ADC_BITS  = 12,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  clpf_pkg::cmd_type         cmd,
   output clpf_pkg::status_type      status,
   input  logic [ADC_BITS-1:0]       adc_sample,
   input  logic [clpf_pkg::DT_W-1:0] elapsed_ms,
   input  logic                      csr_wr_en,
   input  logic [clpf_pkg::T_W-1:0]  csr_wr_data,
   output logic [clpf_pkg::PSI_W-1:0] filtered_psi
);
   import clpf_pkg::*;

   localparam int unsigned RAW_W   = ADC_BITS + 1;
   localparam int unsigned Y_W     = PSI_W + FRAC_BITS;
   localparam int unsigned PROD_W  = T_W + Y_W;
   localparam int unsigned NUM_W   = PROD_W + 1;
   localparam int unsigned DIV_W   = T_W + 1;
   localparam int unsigned PB_W    = DT_W + PSI_W;
   localparam int unsigned TWICE_W = CLAMP_W + 1;
   localparam int unsigned SCL_W   = TWICE_W + 5;

   logic [T_W-1:0]    time_ff, time_in;
   logic [Y_W-1:0]    filter_ff, filter_in;
   logic [PSI_W-1:0]  psi_ff, psi_in;
   logic [DT_W-1:0]   dt_ff;
   logic [PROD_W-1:0] prod_a_ff;
   logic [PB_W-1:0]   prod_b_ff;
   logic [DIV_W-1:0]  divisor_ff;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [Y_W-1:0]    quo_ff, quo_in;
   logic [PSI_W-1:0]  out_ff;

   logic [RAW_W-1:0]   raw_ext;
   logic [CLAMP_W-1:0] clamped;
   logic [TWICE_W-1:0] offset;
   logic [SCL_W-1:0]   scaled;
   logic [NUM_W-1:0]   num;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   // Clamp to the 4-20 mA band, then scale to psi.
   always_comb begin
      raw_ext = RAW_W'(adc_sample);
      if (raw_ext < RAW_W'(RAW_LOW)) begin
         clamped = CLAMP_W'(RAW_LOW);
      end else if (raw_ext > RAW_W'(RAW_HIGH)) begin
         clamped = CLAMP_W'(RAW_HIGH);
      end else begin
         clamped = raw_ext[CLAMP_W-1:0];
      end
      offset = {clamped, 1'b0} - TWICE_W'(SCALE_OFF);
      scaled = SCL_W'(offset) * SCL_W'(SCALE_MUL);
      psi_in = PSI_W'(scaled >> SCALE_SHIFT);
   end

   assign time_in = csr_wr_en ? csr_wr_data : time_ff;
   assign num     = NUM_W'(prod_a_ff) + (NUM_W'(prod_b_ff) << FRAC_BITS);

   // One quotient bit per step; the remainder always stays below the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[Y_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      if (cmd.div_init) begin
         rem_in = num[NUM_W-1:Y_W];
         quo_in = num[Y_W-1:0];
      end else if (trial >= {1'b0, divisor_ff}) begin
         rem_in = diff[DIV_W-1:0];
         quo_in = {quo_ff[Y_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DIV_W-1:0];
         quo_in = {quo_ff[Y_W-2:0], 1'b0};
      end
   end

   assign filter_in = (cmd.commit && !status.dt_zero) ? quo_ff : filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= T_RESET;
         filter_ff <= '0;
      end else begin
         time_ff   <= time_in;
         filter_ff <= filter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         psi_ff <= psi_in;
         dt_ff  <= elapsed_ms;
      end
      if (cmd.mul_en) begin
         prod_a_ff  <= PROD_W'(time_ff) * PROD_W'(filter_ff);
         prod_b_ff  <= PB_W'(dt_ff) * PB_W'(psi_ff);
         divisor_ff <= DIV_W'(time_ff) + DIV_W'(dt_ff);
      end
      if (cmd.div_init || cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.commit) begin
         out_ff <= filter_in[Y_W-1:FRAC_BITS];
      end
   end

   assign status.dt_zero = (dt_ff == '0);
   assign filtered_psi   = out_ff;

endmodule

// ----- rtl/clpf_controller.sv -----
// Controller of the current-loop pressure low-pass filter: sequences load,
// multiply, sum, the divider steps and the result hand-off.
// Depends on clpf_pkg.
module clpf_controller #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output clpf_pkg::cmd_type    cmd,
   input  clpf_pkg::status_type status
);
   import clpf_pkg::*;

   localparam int unsigned STEPS = PSI_W + FRAC_BITS;
   localparam int unsigned CNT_W = $clog2(STEPS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;
   logic             out_free;
   logic             last_step;

   assign out_free  = !valid_ff || rsp_tready;
   assign last_step = (count_ff == CNT_W'(STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = status.dt_zero ? ST_DONE : ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_MUL: begin
            cmd.mul_en = !status.dt_zero;
         end
         ST_SUM: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.div_init) begin
         count_in = '0;
      end else if (cmd.div_step) begin
         count_in = count_ff + 1'b1;
      end
   end

   // The result register is reloaded only when it is empty or being taken.
   always_comb begin
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ----- rtl/current_loop_pressure_low_pass_core.sv -----
// Top level of the current-loop pressure low-pass filter.
// Depends on clpf_pkg, clpf_controller and clpf_datapath.
//
//   Channel  Direction  Payload
//   req_*    in         adc_sample, elapsed_ms
//   rsp_*    out        filtered_psi
//   csr_*    in         filter_time_ms (write only)
//
// An item passes from acceptance through the multiply, sum and divide states to its result,
// set by the restoring divider, which retires one quotient bit per cycle.
// An item with zero elapsed time skips the arithmetic.
// Reset is synchronous; it sets the filter state to zero and the time constant to 500.
// A stalled result holds in the output register while the next beat is accepted;
// the divider then waits in its final state until that register is free.
module current_loop_pressure_low_pass_core #(
   parameter int unsigned ADC_BITS  = 12,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // [ADC_BITS-1:0] adc_sample, [ADC_BITS+15:ADC_BITS] elapsed_ms, zero padding above
   input  logic [((ADC_BITS + clpf_pkg::DT_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // [10:0] filtered_psi, zero padding above
   output logic [15:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  logic [clpf_pkg::T_W-1:0] csr_wr_data
);
   import clpf_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [PSI_W-1:0]  filtered_psi;

   clpf_controller #(
      .FRAC_BITS(FRAC_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   clpf_datapath #(
      .ADC_BITS (ADC_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .adc_sample  (req_tdata[ADC_BITS-1:0]),
      .elapsed_ms  (req_tdata[ADC_BITS+DT_W-1:ADC_BITS]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .filtered_psi(filtered_psi)
   );

   assign rsp_tdata = {{(16 - PSI_W){1'b0}}, filtered_psi};

endmodule
